// ===== rtl/nfwa_pkg.sv =====
// shared constants, types and helpers for the nfa word acceptor
`timescale 1ns / 1ps
`default_nettype none

package nfwa_pkg;

  localparam int NUM_STATES  = 128;
  localparam int NUM_SYMBOLS = 26;

  localparam int OP_W    = 3;
  localparam int STATE_W = 7;
  localparam int SYM_W   = 5;

  // transition memory row = {source state, symbol}
  localparam int ADDR_W = STATE_W + SYM_W;
  localparam int DEPTH  = 1 << ADDR_W;

  typedef logic [NUM_STATES-1:0] set_t;

  typedef enum logic [OP_W-1:0] {
    OP_DECLARE = 3'd0,
    OP_TRANS   = 3'd1,
    OP_FINAL   = 3'd2,
    OP_SYMBOL  = 3'd3,
    OP_END     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_LAST
  } fsm_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic set_t state_bit(input logic [STATE_W-1:0] idx);
    set_t s;
    s = '0;
    if (int'(idx) < NUM_STATES) begin
      s[idx] = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nfwa_tmem.sv =====
// transition set memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module nfwa_tmem (
  input  wire logic               clk,
  input  wire nfwa_pkg::mem_req_t req,
  input  wire nfwa_pkg::set_t     wdata,
  output nfwa_pkg::set_t          rdata
);

  nfwa_pkg::set_t mem [nfwa_pkg::DEPTH];
  nfwa_pkg::set_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/nfa_word_acceptor.sv =====
// nfa word acceptor top level: sequencer, active set tracking and result register
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_op, in_state_a, in_state_b, in_symbol
// out_      output     out_valid / out_ready  out_accepted, out_dead
// cfg_      input      cfg_wr_en              cfg_wr_data (start state)
//
// declare, mark final, end of word, unused codes, out-of-range symbols and dropped transitions
// are handled in idle; add transition reads one memory row in idle and writes it back in rmw.
// a word symbol reads one memory row per source state, 128 states, through the one read port,
// then the last state masks the gathered set with the declared states.
// after reset a clearing pass writes all 4096 memory rows, one per cycle, with in_ready low.
// every input item waits in idle while a result is held and out_ready is low.

module nfa_word_acceptor (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [nfwa_pkg::OP_W-1:0]    in_op,
  input  wire logic [nfwa_pkg::STATE_W-1:0] in_state_a,
  input  wire logic [nfwa_pkg::STATE_W-1:0] in_state_b,
  input  wire logic [nfwa_pkg::SYM_W-1:0]   in_symbol,

  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_accepted,
  output logic                              out_dead,

  input  wire logic                         cfg_wr_en,
  input  wire logic [nfwa_pkg::STATE_W-1:0] cfg_wr_data
);

  nfwa_pkg::fsm_t st_r, st_nxt;

  logic [nfwa_pkg::ADDR_W-1:0]  cnt_r;
  logic [nfwa_pkg::STATE_W-1:0] start_state_r;
  logic [nfwa_pkg::STATE_W-1:0] b_r;
  logic [nfwa_pkg::SYM_W-1:0]   sym_r;
  logic [nfwa_pkg::ADDR_W-1:0]  row_r;
  logic                         in_word_r;
  logic                         take_r;
  nfwa_pkg::set_t               declared_r;
  nfwa_pkg::set_t               final_r;
  nfwa_pkg::set_t               active_r;
  nfwa_pkg::set_t               acc_r;
  logic                         out_valid_r;
  logic                         out_accepted_r;
  logic                         out_dead_r;

  nfwa_pkg::mem_req_t           mem_req;
  nfwa_pkg::set_t               mem_wdata;
  nfwa_pkg::set_t               mem_rdata;
  nfwa_pkg::set_t               cur_set;
  nfwa_pkg::set_t               acc_in;
  nfwa_pkg::op_t                op;
  logic                         accept;
  logic                         sym_ok;
  logic                         trans_ok;
  logic                         scan_done;

  assign op       = nfwa_pkg::op_t'(in_op);
  assign accept   = in_valid && in_ready;
  assign sym_ok   = int'(in_symbol) < nfwa_pkg::NUM_SYMBOLS;
  assign trans_ok = sym_ok && (int'(in_state_a) < nfwa_pkg::NUM_STATES)
                    && (int'(in_state_b) < nfwa_pkg::NUM_STATES);
  assign scan_done = (cnt_r[nfwa_pkg::STATE_W-1:0] == '1);

  // active set as seen at word start: start state alone
  assign cur_set = in_word_r ? active_r : nfwa_pkg::state_bit(start_state_r);
  assign acc_in  = take_r ? (acc_r | mem_rdata) : acc_r;

  nfwa_tmem u_tmem (
    .clk   (clk),
    .req   (mem_req),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      nfwa_pkg::ST_CLEAR: begin
        if (cnt_r == '1) begin
          st_nxt = nfwa_pkg::ST_IDLE;
        end
      end
      nfwa_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == nfwa_pkg::OP_TRANS && trans_ok) begin
            st_nxt = nfwa_pkg::ST_RMW;
          end else if (op == nfwa_pkg::OP_SYMBOL && sym_ok) begin
            st_nxt = nfwa_pkg::ST_SCAN;
          end
        end
      end
      nfwa_pkg::ST_RMW:  st_nxt = nfwa_pkg::ST_IDLE;
      nfwa_pkg::ST_SCAN: begin
        if (scan_done) begin
          st_nxt = nfwa_pkg::ST_LAST;
        end
      end
      nfwa_pkg::ST_LAST: st_nxt = nfwa_pkg::ST_IDLE;
      default:           st_nxt = nfwa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = row_r;
    mem_req.raddr = {in_state_a, in_symbol};
    mem_wdata     = mem_rdata | nfwa_pkg::state_bit(b_r);
    case (st_r)
      nfwa_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_wdata     = '0;
      end
      nfwa_pkg::ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
      end
      nfwa_pkg::ST_RMW: begin
        mem_req.we = 1'b1;
      end
      nfwa_pkg::ST_SCAN: begin
        mem_req.raddr = {cnt_r[nfwa_pkg::STATE_W-1:0], sym_r};
      end
      nfwa_pkg::ST_LAST: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= nfwa_pkg::ST_CLEAR;
      cnt_r         <= '0;
      start_state_r <= '0;
      in_word_r     <= 1'b0;
      take_r        <= 1'b0;
      declared_r    <= '0;
      final_r       <= '0;
      active_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;

      if (cfg_wr_en) begin
        start_state_r <= cfg_wr_data;
      end

      if (out_valid_r && out_ready && !(accept && op == nfwa_pkg::OP_END)) begin
        out_valid_r <= 1'b0;
      end

      take_r <= 1'b0;
      case (st_r)
        nfwa_pkg::ST_CLEAR: cnt_r <= cnt_r + 1'b1;
        nfwa_pkg::ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            case (op)
              nfwa_pkg::OP_DECLARE: declared_r <= declared_r | nfwa_pkg::state_bit(in_state_a);
              nfwa_pkg::OP_FINAL:   final_r <= final_r | nfwa_pkg::state_bit(in_state_a);
              nfwa_pkg::OP_TRANS:   ;
              nfwa_pkg::OP_SYMBOL: begin
                in_word_r <= 1'b1;
                // out-of-range symbol has no transitions
                active_r  <= sym_ok ? cur_set : '0;
              end
              nfwa_pkg::OP_END: begin
                in_word_r   <= 1'b0;
                active_r    <= '0;
                out_valid_r <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        nfwa_pkg::ST_SCAN: begin
          cnt_r  <= cnt_r + 1'b1;
          take_r <= active_r[cnt_r[nfwa_pkg::STATE_W-1:0]];
        end
        nfwa_pkg::ST_LAST: active_r <= acc_in & declared_r;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (st_r == nfwa_pkg::ST_IDLE) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_in;
    end
    if (accept) begin
      b_r   <= in_state_b;
      sym_r <= in_symbol;
      row_r <= {in_state_a, in_symbol};
    end
    if (accept && op == nfwa_pkg::OP_END) begin
      out_accepted_r <= |(cur_set & final_r);
      out_dead_r     <= ~|cur_set;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_accepted = out_accepted_r;
  assign out_dead     = out_dead_r;

endmodule

`default_nettype wire

// ===== test/tb_nfa_word_acceptor.sv =====
// testbench for the nfa word acceptor: directed words, then random automata and words
`timescale 1ns / 1ps

module tb_nfa_word_acceptor;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 160;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASE_ITEMS   = 150;

  // codes that the block ignores
  localparam logic [nfwa_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [nfwa_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic accepted;
    logic dead;
  } verdict_t;

  typedef struct packed {
    logic [nfwa_pkg::OP_W-1:0]    op;
    logic [nfwa_pkg::STATE_W-1:0] a;
    logic [nfwa_pkg::STATE_W-1:0] b;
    logic [nfwa_pkg::SYM_W-1:0]   sym;
    bit                           typed;
    bit                           acc;
    bit                           dead;
  } step_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [nfwa_pkg::OP_W-1:0]    in_op;
  logic [nfwa_pkg::STATE_W-1:0] in_state_a;
  logic [nfwa_pkg::STATE_W-1:0] in_state_b;
  logic [nfwa_pkg::SYM_W-1:0]   in_symbol;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_accepted;
  logic                         out_dead;
  logic                         cfg_wr_en;
  logic [nfwa_pkg::STATE_W-1:0] cfg_wr_data;

  // predicted automaton
  nfwa_pkg::set_t               nfa_trans [nfwa_pkg::NUM_STATES*nfwa_pkg::NUM_SYMBOLS];
  nfwa_pkg::set_t               nfa_declared;
  nfwa_pkg::set_t               nfa_final;
  nfwa_pkg::set_t               nfa_active;
  bit                           nfa_in_word;
  logic [nfwa_pkg::STATE_W-1:0] nfa_start;

  verdict_t verdicts_due[$];
  int       mismatch_count;
  int       items_sent;
  int       cycle_count;
  int       burst_left;
  int       state_base;
  int       sym_base;

  // op, a, b, symbol, typed, accepted, dead
  step_row_t directed_steps [0:26] = '{
    '{nfwa_pkg::OP_END,     0,   0,   0,  1, 0, 0},  // empty word, undeclared start still live
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_END,     0,   0,   0,  1, 0, 1},  // no transitions, word dies
    '{nfwa_pkg::OP_DECLARE, 0,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_DECLARE, 127, 0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_FINAL,   127, 0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_TRANS,   0,   127, 0,  0, 0, 0},
    '{nfwa_pkg::OP_TRANS,   127, 0,   25, 0, 0, 0},
    '{nfwa_pkg::OP_TRANS,   0,   127, 31, 0, 0, 0},  // symbol out of range, dropped
    '{nfwa_pkg::OP_TRANS,   0,   5,   25, 0, 0, 0},  // target not declared yet
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_END,     0,   0,   0,  1, 1, 0},
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   25, 0, 0, 0},
    '{nfwa_pkg::OP_END,     0,   0,   0,  1, 0, 0},
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   31, 0, 0, 0},
    '{nfwa_pkg::OP_END,     0,   0,   0,  1, 0, 1},
    '{nfwa_pkg::OP_FINAL,   0,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_END,     0,   0,   0,  1, 1, 0},  // empty word, start is final
    '{OP_RSVD5,             127, 127, 31, 0, 0, 0},
    '{OP_RSVD7,             127, 0,   31, 0, 0, 0},
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   25, 0, 0, 0},
    '{nfwa_pkg::OP_DECLARE, 5,   0,   0,  0, 0, 0},  // declared mid word
    '{nfwa_pkg::OP_SYMBOL,  0,   0,   25, 0, 0, 0},
    '{nfwa_pkg::OP_FINAL,   5,   0,   0,  0, 0, 0},
    '{nfwa_pkg::OP_END,     0,   0,   0,  0, 0, 0}
  };

  nfa_word_acceptor dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_state_a   (in_state_a),
    .in_state_b   (in_state_b),
    .in_symbol    (in_symbol),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accepted (out_accepted),
    .out_dead     (out_dead),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void open_word();
    if (!nfa_in_word) begin
      nfa_active = '0;
      if (nfa_start < nfwa_pkg::NUM_STATES) begin
        nfa_active[nfa_start] = 1'b1;
      end
      nfa_in_word = 1'b1;
    end
  endfunction

  function automatic void nfa_step(input logic [nfwa_pkg::OP_W-1:0] op,
                                   input logic [nfwa_pkg::STATE_W-1:0] a,
                                   input logic [nfwa_pkg::STATE_W-1:0] b,
                                   input logic [nfwa_pkg::SYM_W-1:0] sym,
                                   output bit has_verdict, output verdict_t v);
    nfwa_pkg::set_t nxt;
    has_verdict = 1'b0;
    v = '0;
    case (op)
      nfwa_pkg::OP_DECLARE: begin
        if (a < nfwa_pkg::NUM_STATES) nfa_declared[a] = 1'b1;
      end
      nfwa_pkg::OP_TRANS: begin
        if (a < nfwa_pkg::NUM_STATES && b < nfwa_pkg::NUM_STATES
            && sym < nfwa_pkg::NUM_SYMBOLS) begin
          nfa_trans[int'(a) * nfwa_pkg::NUM_SYMBOLS + int'(sym)][b] = 1'b1;
        end
      end
      nfwa_pkg::OP_FINAL: begin
        if (a < nfwa_pkg::NUM_STATES) nfa_final[a] = 1'b1;
      end
      nfwa_pkg::OP_SYMBOL: begin
        open_word();
        nxt = '0;
        if (sym < nfwa_pkg::NUM_SYMBOLS) begin
          for (int s = 0; s < nfwa_pkg::NUM_STATES; s++) begin
            if (nfa_active[s]) nxt |= nfa_trans[s * nfwa_pkg::NUM_SYMBOLS + int'(sym)];
          end
          nxt &= nfa_declared;
        end
        nfa_active = nxt;
      end
      nfwa_pkg::OP_END: begin
        open_word();
        v.accepted  = |(nfa_active & nfa_final);
        v.dead      = ~|nfa_active;
        has_verdict = 1'b1;
        nfa_in_word = 1'b0;
        nfa_active  = '0;
      end
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones, and bursts with none
  function automatic int pick_gap();
    int r;
    if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [nfwa_pkg::STATE_W-1:0] pool_state();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
    return state_base + $urandom_range(0, 7);
  endfunction

  function automatic logic [nfwa_pkg::SYM_W-1:0] pool_sym();
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 31);
    return sym_base + $urandom_range(0, 3);
  endfunction

  task automatic send_word(input logic [nfwa_pkg::OP_W-1:0] op,
                           input logic [nfwa_pkg::STATE_W-1:0] a,
                           input logic [nfwa_pkg::STATE_W-1:0] b,
                           input logic [nfwa_pkg::SYM_W-1:0] sym,
                           input bit typed, input bit t_acc, input bit t_dead);
    int       gap;
    bit       has_verdict;
    verdict_t v;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_state_a <= a;
    in_state_b <= b;
    in_symbol  <= sym;
    do @(posedge clk); while (!in_ready);
    nfa_step(op, a, b, sym, has_verdict, v);
    if (has_verdict) begin
      if (typed) begin
        v.accepted = t_acc;
        v.dead     = t_dead;
      end
      verdicts_due.push_back(v);
    end
    if (op <= nfwa_pkg::OP_END) items_sent++;
  endtask

  // symbols produce no result, so let the last one finish before touching the register
  task automatic write_start(input logic [nfwa_pkg::STATE_W-1:0] value);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    nfa_start = value;
  endtask

  task automatic random_definition();
    case ($urandom_range(0, 2))
      0:       send_word(nfwa_pkg::OP_DECLARE, pool_state(), 7'd0, 5'd0, 1'b0, 1'b0, 1'b0);
      1:       send_word(nfwa_pkg::OP_TRANS, pool_state(), pool_state(), pool_sym(),
                         1'b0, 1'b0, 1'b0);
      default: send_word(nfwa_pkg::OP_FINAL, pool_state(), 7'd0, 5'd0, 1'b0, 1'b0, 1'b0);
    endcase
  endtask

  initial begin
    int ready_hold;
    int r;
    ready_hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (ready_hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          out_ready  <= 1'b1;
          ready_hold = $urandom_range(20, 80);
        end else if (r < 80) begin
          out_ready  <= $urandom_range(0, 1);
          ready_hold = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_ready  <= 1'b0;
          ready_hold = $urandom_range(4, 10);
        end else begin
          out_ready  <= 1'b0;
          ready_hold = $urandom_range(20, 40);
        end
      end else begin
        ready_hold--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual accepted=%0b dead=%0b",
                 $time, out_accepted, out_dead);
        mismatch_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_accepted !== want.accepted) begin
          $display("%0t: accepted mismatch, expected %0b, actual %0b",
                   $time, want.accepted, out_accepted);
          mismatch_count++;
        end
        if (out_dead !== want.dead) begin
          $display("%0t: dead mismatch, expected %0b, actual %0b", $time, want.dead, out_dead);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int phase_start;
    int len;
    logic [nfwa_pkg::STATE_W-1:0] start;
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    burst_left     = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = nfwa_pkg::OP_DECLARE;
    in_state_a     = '0;
    in_state_b     = '0;
    in_symbol      = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    for (int i = 0; i < nfwa_pkg::NUM_STATES * nfwa_pkg::NUM_SYMBOLS; i++) nfa_trans[i] = '0;
    nfa_declared = '0;
    nfa_final    = '0;
    nfa_active   = '0;
    nfa_in_word  = 1'b0;
    nfa_start    = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      send_word(directed_steps[i].op, directed_steps[i].a, directed_steps[i].b,
                directed_steps[i].sym, directed_steps[i].typed, directed_steps[i].acc,
                directed_steps[i].dead);
    end

    // each phase adds a small automaton on a slice of states and symbols to what earlier phases built
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        state_base = 120;
        sym_base   = 22;
        start      = 7'd127;
      end else if (phase == 1) begin
        state_base = 0;
        sym_base   = 0;
        start      = 7'd0;
      end else begin
        state_base = $urandom_range(0, 120);
        sym_base   = $urandom_range(0, 22);
        if ($urandom_range(0, 4) == 0) start = $urandom_range(0, 127);
        else start = state_base + $urandom_range(0, 7);
      end
      write_start(start);
      phase_start = items_sent;

      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          send_word(nfwa_pkg::OP_DECLARE, state_base + i, 7'd0, 5'd0, 1'b0, 1'b0, 1'b0);
        end
      end
      repeat (2) send_word(nfwa_pkg::OP_FINAL, pool_state(), 7'd0, 5'd0, 1'b0, 1'b0, 1'b0);
      repeat (12) send_word(nfwa_pkg::OP_TRANS, pool_state(), pool_state(), pool_sym(),
                            1'b0, 1'b0, 1'b0);

      while (items_sent - phase_start < PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(0, 6);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) random_definition();
            send_word(nfwa_pkg::OP_SYMBOL, $urandom_range(0, 127), $urandom_range(0, 127),
                      pool_sym(), 1'b0, 1'b0, 1'b0);
          end
          send_word(nfwa_pkg::OP_END, $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 31), 1'b0, 1'b0, 1'b0);
        end else begin
          send_word($urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 127),
                    $urandom_range(0, 31), 1'b0, 1'b0, 1'b0);
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
